// File: hdl/joystick_radial_deadzone_normalizer_top_defines.svh
// Assertion macros for the deadzone normalizer.
`ifndef JOYSTICK_RADIAL_DEADZONE_NORMALIZER_TOP_DEFINES_SVH
`define JOYSTICK_RADIAL_DEADZONE_NORMALIZER_TOP_DEFINES_SVH

// a implies b on the same edge
`define JRDN_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// a implies b on the next edge
`define JRDN_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// File: hdl/jrdn_pkg.sv
`timescale 1ns / 1ps
package jrdn_pkg;
    typedef struct packed {
        logic signed [15:0] stick_x;
        logic signed [15:0] stick_y;
        logic               use_left;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic               in_deadzone;
    } t_out_item;

    localparam logic [0:0] REG_LEFT_RADIUS  = 1'b0;
    localparam logic [0:0] REG_RIGHT_RADIUS = 1'b1;
    localparam logic [14:0] LEFT_RESET  = 15'd7849;
    localparam logic [14:0] RIGHT_RESET = 15'd8689;
    localparam logic [15:0] OUT_MAX = 16'd32767;
endpackage

// File: hdl/joystick_radial_deadzone_normalizer_top.sv
`timescale 1ns / 1ps
// Steps: square, sqrt (one root bit per stage), then divide.
// Throughput: one item per cycle; start is honored every cycle, busy stays low.
// Every item yields one result strobe exactly once; the receiver cannot stall.
// Reset (synchronous, active low) clears all valid bits and restores both radii.
module joystick_radial_deadzone_normalizer_top #(
    parameter int FRAC_BITS = 15
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  jrdn_pkg::t_in_item  i_item,
    output logic                o_strobe,
    output jrdn_pkg::t_out_item o_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [0:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import jrdn_pkg::*;
    `include "joystick_radial_deadzone_normalizer_top_defines.svh"

    localparam int SQ = 16;  // sqrt stages

    logic [14:0] r_left, r_right;
    assign o_cfg_ready = 1'b1;
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= LEFT_RESET;
            r_right <= RIGHT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LEFT_RADIUS:  r_left  <= i_cfg_data[14:0];
                REG_RIGHT_RADIUS: r_right <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Stage 0: squares and deadzone test. s <= 2^31 always.
    logic        r0_v, r0_dz, r0_nx, r0_ny;
    logic [31:0] r0_s;
    logic [15:0] r0_mx, r0_my;
    logic [15:0] n_ax, n_ay;
    logic [14:0] n_rad;
    logic [29:0] n_r2;
    logic [31:0] n_s;
    always_comb begin
        n_ax  = i_item.stick_x[15] ? 16'd0 - i_item.stick_x : i_item.stick_x;
        n_ay  = i_item.stick_y[15] ? 16'd0 - i_item.stick_y : i_item.stick_y;
        n_rad = i_item.use_left ? r_left : r_right;
        n_r2  = n_rad * n_rad;
        n_s   = n_ax * n_ax + n_ay * n_ay;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r0_v <= 1'b0;
        else          r0_v <= start;
        r0_s  <= n_s;
        r0_dz <= (n_s == 32'd0) || (n_s < {2'b0, n_r2});
        r0_mx <= n_ax;
        r0_my <= n_ay;
        r0_nx <= i_item.stick_x[15];
        r0_ny <= ~i_item.stick_y[15] && (i_item.stick_y != 16'sd0); // -y sign
    end

    // Sqrt pipeline: one root bit per stage, digit-by-digit.
    logic [SQ:0]  q_v, q_dz, q_nx, q_ny;
    logic [31:0]  q_s  [SQ+1];
    logic [15:0]  q_rt [SQ+1];
    logic [15:0]  q_mx [SQ+1];
    logic [15:0]  q_my [SQ+1];
    always_comb begin
        q_v[0] = r0_v; q_dz[0] = r0_dz; q_nx[0] = r0_nx; q_ny[0] = r0_ny;
        q_s[0] = r0_s; q_rt[0] = '0; q_mx[0] = r0_mx; q_my[0] = r0_my;
    end
    for (genvar k = 0; k < SQ; k++) begin : g_sq
        logic [15:0] n_c;
        always_comb n_c = q_rt[k] | (16'd1 << (SQ - 1 - k));
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) q_v[k+1] <= 1'b0;
            else          q_v[k+1] <= q_v[k];
            q_dz[k+1] <= q_dz[k]; q_nx[k+1] <= q_nx[k]; q_ny[k+1] <= q_ny[k];
            q_s[k+1]  <= q_s[k];  q_mx[k+1] <= q_mx[k]; q_my[k+1] <= q_my[k];
            q_rt[k+1] <= ({16'd0, n_c} * {16'd0, n_c} <= q_s[k]) ? n_c : q_rt[k];
        end
    end

    logic        dx_v, dy_v;
    logic [15:0] dx_q, dy_q;
    jrdn_divider #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_v[SQ]), .i_mag(q_mx[SQ]),
        .i_neg(q_nx[SQ]), .i_div(q_rt[SQ]), .o_valid(dx_v), .o_q(dx_q));
    jrdn_divider #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_v[SQ]), .i_mag(q_my[SQ]),
        .i_neg(q_ny[SQ]), .i_div(q_rt[SQ]), .o_valid(dy_v), .o_q(dy_q));

    // Deadzone flag rides alongside the divider.
    localparam int DL = 16 + FRAC_BITS + 1;
    logic [DL-1:0] r_dzl;
    always_ff @(posedge i_clk) r_dzl <= {r_dzl[DL-2:0], q_dz[SQ]};

    always_comb begin
        o_strobe           = dx_v;
        o_item.in_deadzone = r_dzl[DL-1];
        o_item.dir_x       = r_dzl[DL-1] ? 16'sd0 : dx_q;
        o_item.dir_y       = r_dzl[DL-1] ? 16'sd0 : dy_q;
    end

    `JRDN_ASSERT_IMP(a_lanes_agree, i_clk, i_rst_n, dx_v, dy_v)
    `JRDN_ASSERT_IMP(a_dz_zero, i_clk, i_rst_n, o_strobe && o_item.in_deadzone,
        o_item.dir_x == 16'sd0 && o_item.dir_y == 16'sd0)
    `JRDN_ASSERT_NEXT(a_sq_flow, i_clk, i_rst_n, r0_v, q_v[1])
endmodule

// File: hdl/jrdn_divider.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage.
// Quotient saturates to OUT_MAX, sign applied at the output.
module jrdn_divider #(
    parameter int FRAC_BITS = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [15:0] i_mag,     // |v|, up to 32768
    input  logic        i_neg,
    input  logic [15:0] i_div,     // m >= 1 when used
    output logic        o_valid,
    output logic [15:0] o_q
);
    import jrdn_pkg::*;

    localparam int QW = 16 + FRAC_BITS + 1;  // dividend bits
    localparam int NS = QW;                  // one stage per bit
    localparam int RW = 17;                  // remainder width

    logic [NS:0]            r_v;
    logic [QW-1:0]          r_num [NS+1];
    logic [RW-1:0]          r_rem [NS+1];
    logic [15:0]            r_dv  [NS+1];
    logic [NS:0]            r_ng;

    always_comb begin
        r_num[0] = {{(QW-16){1'b0}}, i_mag} << FRAC_BITS;
        r_rem[0] = '0;
        r_dv[0]  = i_div;
        r_v[0]   = i_valid;
        r_ng[0]  = i_neg;
    end

    for (genvar k = 0; k < NS; k++) begin : g_st
        logic [RW:0] n_try;
        logic [RW-1:0] n_sh;
        always_comb begin
            n_sh  = {r_rem[k][RW-2:0], r_num[k][QW-1]};
            n_try = {1'b0, n_sh} - {2'b0, r_dv[k]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
            r_dv[k+1] <= r_dv[k];
            r_ng[k+1] <= r_ng[k];
            if (!n_try[RW]) begin
                r_rem[k+1] <= n_try[RW-1:0];
                r_num[k+1] <= {r_num[k][QW-2:0], 1'b1};
            end else begin
                r_rem[k+1] <= n_sh;
                r_num[k+1] <= {r_num[k][QW-2:0], 1'b0};
            end
        end
    end

    logic [15:0] n_sat;
    always_comb begin
        n_sat = (r_num[NS] > {{(QW-16){1'b0}}, OUT_MAX}) ? OUT_MAX : r_num[NS][15:0];
        o_q   = r_ng[NS] ? (16'd0 - n_sat) : n_sat;
        o_valid = r_v[NS];
    end
endmodule
